// File: hdl/mahd_pkg.sv
// Shared types, widths and constants of the moving average hysteresis detector.
package mahd_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int SAMPLE_W   = 15;
    localparam int WLEN_W     = 5;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int WIN_AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int STREAK_W   = 8;

    localparam logic [STREAK_W-1:0] ON_COUNT   = 8'd2;
    localparam logic [STREAK_W-1:0] OFF_COUNT  = 8'd6;
    localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

    localparam logic [WLEN_W-1:0]   WLEN_RESET   = 5'd7;
    localparam logic [SAMPLE_W-1:0] BRIGHT_RESET = 15'd800;
    localparam logic [SAMPLE_W-1:0] DARK_RESET   = 15'd900;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESH   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [STREAK_W-1:0] streak_inc(input logic [STREAK_W-1:0] s);
        return (s >= STREAK_MAX) ? STREAK_MAX : s + 8'd1;
    endfunction

endpackage

// File: hdl/mahd_ifs.sv
// Valid/ready channel interfaces for sample beats and result beats.
interface mahd_sample_if;
    logic                          valid;
    logic                          ready;
    logic [mahd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mahd_result_if;
    logic                          valid;
    logic                          ready;
    logic [mahd_pkg::SAMPLE_W-1:0] average;
    logic                          light_detected;

    modport source (output valid, output average, output light_detected, input ready);
    modport sink   (input valid, input average, input light_detected, output ready);
endinterface

// File: hdl/mahd_div.sv
// Restoring radix-2 divider: window sum by fill count, one quotient bit per cycle.
module mahd_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mahd_pkg::SUM_W-1:0] dividend,
    input  logic [mahd_pkg::CNT_W-1:0] divisor,
    output logic [mahd_pkg::SUM_W-1:0] quotient,
    output mahd_pkg::div_stat_t        stat
);

    localparam int STEP_W = $clog2(mahd_pkg::SUM_W + 1);

    logic [mahd_pkg::SUM_W-1:0] quo_reg;
    logic [mahd_pkg::CNT_W-1:0] rem_reg;
    logic [mahd_pkg::CNT_W-1:0] div_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [mahd_pkg::CNT_W:0]   trial;
    logic                       fits;

    assign trial = {rem_reg, quo_reg[mahd_pkg::SUM_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(mahd_pkg::SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[mahd_pkg::SUM_W-2:0], fits};
            rem_reg <= fits ? mahd_pkg::CNT_W'(trial - {1'b0, div_reg})
                            : trial[mahd_pkg::CNT_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: hdl/moving_average_hysteresis_detector_top.sv
// Top level of the moving average hysteresis light detector.
//
// Each sample beat enters a sliding window of up to window_length samples
// (clamped to 1..16, zero acts as one) that lives in a small synchronous RAM,
// with a running sum kept in a register. Once the window is full, each new
// sample pushes out the oldest one, so a window that was filled under a longer
// length keeps its fill after the length is lowered. The result beat carries
// the truncated average of the window and the hysteresis flag: the flag turns
// on after two consecutive averages at or below bright_threshold and turns off
// after six consecutive averages at or above dark_threshold. One sample is
// handled at a time. A beat is taken in an idle cycle while the RAM reads the
// oldest entry; then come an update step for the RAM and the running sum,
// the bit-serial divide of the 19-bit sum by the fill count (19 quotient
// bits and a step that flags the end), and a judge step that checks the
// average and loads the output register. The next sample beat is taken only
// once the block is back in idle after the judge step. The output register
// lets the next sample come in while a result beat still waits to be taken;
// only the final judge step of that sample waits, for as long as the previous
// result beat is held by the receiver.
// Registers are to be written through cfg_we/cfg_index/cfg_data by the user
// only while the block is idle; the block itself does not enforce this.
// Indexes beyond the register list are ignored.
module moving_average_hysteresis_detector_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    mahd_sample_if.sink                    sample_ch,
    mahd_result_if.source                  result_ch,
    input  logic                           cfg_we,
    input  logic [mahd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mahd_pkg::CFG_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [mahd_pkg::WLEN_W-1:0]   wlen_reg;
    logic [mahd_pkg::SAMPLE_W-1:0] bright_reg;
    logic [mahd_pkg::SAMPLE_W-1:0] dark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg   <= mahd_pkg::WLEN_RESET;
            bright_reg <= mahd_pkg::BRIGHT_RESET;
            dark_reg   <= mahd_pkg::DARK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mahd_pkg::REG_WINDOW_LENGTH: wlen_reg   <= cfg_data[mahd_pkg::WLEN_W-1:0];
                mahd_pkg::REG_BRIGHT_THRESH: bright_reg <= cfg_data[mahd_pkg::SAMPLE_W-1:0];
                mahd_pkg::REG_DARK_THRESH:   dark_reg   <= cfg_data[mahd_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective window length, clamped into 1..MAX_WINDOW.
    logic [mahd_pkg::CNT_W-1:0] eff_len;

    always_comb
    begin
        if (wlen_reg == '0)
            eff_len = mahd_pkg::CNT_W'(1);
        else if (32'(wlen_reg) > mahd_pkg::MAX_WINDOW)
            eff_len = mahd_pkg::CNT_W'(mahd_pkg::MAX_WINDOW);
        else
            eff_len = mahd_pkg::CNT_W'(wlen_reg);
    end

    // Control and window state.
    mahd_pkg::state_t state_reg, state_next;

    logic [mahd_pkg::CNT_W-1:0]    fill_reg, fill_next;
    logic [mahd_pkg::WIN_AW-1:0]   oldest_reg, oldest_next;
    logic [mahd_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic                          det_on_reg, det_on_next;
    logic [mahd_pkg::STREAK_W-1:0] on_streak_reg, on_streak_next;
    logic [mahd_pkg::STREAK_W-1:0] off_streak_reg, off_streak_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mahd_pkg::SAMPLE_W-1:0] out_avg_reg, out_avg_next;
    logic                          out_det_reg, out_det_next;
    logic [mahd_pkg::SAMPLE_W-1:0] sample_reg;

    // Window RAM: one write port, one registered read port.
    logic [mahd_pkg::SAMPLE_W-1:0] win_mem [mahd_pkg::MAX_WINDOW];
    logic [mahd_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic                          mem_we;
    logic [mahd_pkg::WIN_AW-1:0]   mem_waddr;

    logic                          take;
    logic                          out_free;
    logic                          drop;
    logic [mahd_pkg::CNT_W-1:0]    fill_dec;
    logic [mahd_pkg::CNT_W:0]      slot_sum;
    logic                          div_start;
    logic [mahd_pkg::SUM_W-1:0]    quotient;
    mahd_pkg::div_stat_t           div_stat;
    logic [mahd_pkg::SAMPLE_W-1:0] avg;

    assign sample_ch.ready = (state_reg == mahd_pkg::ST_IDLE);
    assign take            = sample_ch.valid && sample_ch.ready;
    assign out_free        = !out_valid_reg || result_ch.ready;

    // The read of the oldest entry runs every idle cycle, so its data is
    // ready in the update cycle right after the beat is taken.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            win_mem[mem_waddr] <= sample_reg;
        if (state_reg == mahd_pkg::ST_IDLE)
            rd_data_reg <= win_mem[oldest_reg];
        if (take)
            sample_reg <= sample_ch.sample;
    end

    assign drop     = (fill_reg >= eff_len);
    assign fill_dec = drop ? fill_reg - 1'b1 : fill_reg;
    assign slot_sum = {1'b0, mahd_pkg::CNT_W'(oldest_next)} + {1'b0, fill_dec};
    assign avg      = quotient[mahd_pkg::SAMPLE_W-1:0];

    mahd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        oldest_next     = oldest_reg;
        sum_next        = sum_reg;
        det_on_next     = det_on_reg;
        on_streak_next  = on_streak_reg;
        off_streak_next = off_streak_reg;
        out_valid_next  = out_valid_reg && !result_ch.ready;
        out_avg_next    = out_avg_reg;
        out_det_next    = out_det_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        div_start       = 1'b0;

        unique case (state_reg)
            mahd_pkg::ST_IDLE:
            begin
                if (take)
                    state_next = mahd_pkg::ST_UPDATE;
            end
            mahd_pkg::ST_UPDATE:
            begin
                // Retire the oldest sample when the window is full, then
                // append the new one behind the remaining samples.
                if (drop)
                begin
                    sum_next = sum_reg - mahd_pkg::SUM_W'(rd_data_reg);
                    if (oldest_reg == mahd_pkg::WIN_AW'(mahd_pkg::MAX_WINDOW - 1))
                        oldest_next = '0;
                    else
                        oldest_next = oldest_reg + 1'b1;
                end
                sum_next  = sum_next + mahd_pkg::SUM_W'(sample_reg);
                fill_next = fill_dec + 1'b1;
                mem_we    = 1'b1;
                if (slot_sum >= (mahd_pkg::CNT_W + 1)'(mahd_pkg::MAX_WINDOW))
                    mem_waddr = mahd_pkg::WIN_AW'(slot_sum
                                - (mahd_pkg::CNT_W + 1)'(mahd_pkg::MAX_WINDOW));
                else
                    mem_waddr = mahd_pkg::WIN_AW'(slot_sum);
                div_start  = 1'b1;
                state_next = mahd_pkg::ST_DIV;
            end
            mahd_pkg::ST_DIV:
            begin
                if (div_stat.done)
                    state_next = mahd_pkg::ST_DONE;
            end
            mahd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    if (!det_on_reg)
                    begin
                        if (avg <= bright_reg)
                        begin
                            on_streak_next  = mahd_pkg::streak_inc(on_streak_reg);
                            off_streak_next = '0;
                        end
                        else
                        begin
                            off_streak_next = mahd_pkg::streak_inc(off_streak_reg);
                            on_streak_next  = '0;
                        end
                        if (on_streak_next >= mahd_pkg::ON_COUNT)
                            det_on_next = 1'b1;
                    end
                    else
                    begin
                        if (avg >= dark_reg)
                        begin
                            off_streak_next = mahd_pkg::streak_inc(off_streak_reg);
                            on_streak_next  = '0;
                        end
                        else
                        begin
                            on_streak_next  = mahd_pkg::streak_inc(on_streak_reg);
                            off_streak_next = '0;
                        end
                        if (off_streak_next >= mahd_pkg::OFF_COUNT)
                            det_on_next = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    out_avg_next   = avg;
                    out_det_next   = det_on_next;
                    state_next     = mahd_pkg::ST_IDLE;
                end
            end
            default: state_next = mahd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mahd_pkg::ST_IDLE;
            fill_reg       <= '0;
            oldest_reg     <= '0;
            sum_reg        <= '0;
            det_on_reg     <= 1'b0;
            on_streak_reg  <= '0;
            off_streak_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            oldest_reg     <= oldest_next;
            sum_reg        <= sum_next;
            det_on_reg     <= det_on_next;
            on_streak_reg  <= on_streak_next;
            off_streak_reg <= off_streak_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_avg_reg <= out_avg_next;
        out_det_reg <= out_det_next;
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.average        = out_avg_reg;
    assign result_ch.light_detected = out_det_reg;

    // The fill count never exceeds the RAM depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= mahd_pkg::MAX_WINDOW)
        else $error("fill count beyond window depth");

    // After an update the window holds at least one sample.
    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mahd_pkg::ST_UPDATE |=> fill_reg != '0)
        else $error("window empty after update");

    // The divider is never restarted while still iterating.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // The detector flag moves only when a result is loaded.
    a_det_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(det_on_reg) |-> $past(state_reg) == mahd_pkg::ST_DONE)
        else $error("detector flag changed outside result load");

endmodule

// File: tb/moving_average_hysteresis_detector_top_tb.sv
// Self-checking testbench of the moving average hysteresis light detector.
module moving_average_hysteresis_detector_top_tb;

    // Cycles without any accepted beat before the run is declared hung. The
    // slowest correct beat is a long sender gap, a long receiver stall and the
    // block's own processing, so this leaves a wide margin.
    localparam int HANG_LIMIT   = 3000;
    // Cycles allowed after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 30;
    // Register index with no register behind it; writes there must be ignored.
    localparam logic [mahd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SAMPLE_MAX = (1 << mahd_pkg::SAMPLE_W) - 1;

    // One sample beat waiting to be sent. A held beat is not offered until
    // every result already predicted has come back.
    typedef struct {
        logic [mahd_pkg::SAMPLE_W-1:0] sample;
        bit                            hold_off;
    } sample_beat_t;

    // One result beat as the block should produce it.
    typedef struct packed {
        logic [mahd_pkg::SAMPLE_W-1:0] average;
        logic                          light_detected;
    } reading_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           cfg_we;
    logic [mahd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mahd_pkg::CFG_W-1:0]     cfg_data;

    mahd_sample_if sample_ch ();
    mahd_result_if result_ch ();

    moving_average_hysteresis_detector_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Samples still to be sent, and readings predicted but not yet received.
    sample_beat_t samples_to_send[$];
    reading_t     readings_in_flight[$];

    // Our own copy of the registers, tracking every write we make.
    logic [mahd_pkg::WLEN_W-1:0]   cfg_window_length = mahd_pkg::WLEN_RESET;
    logic [mahd_pkg::SAMPLE_W-1:0] cfg_bright        = mahd_pkg::BRIGHT_RESET;
    logic [mahd_pkg::SAMPLE_W-1:0] cfg_dark          = mahd_pkg::DARK_RESET;

    // Our own copy of the window and the detector.
    logic [mahd_pkg::SAMPLE_W-1:0] win_mem [mahd_pkg::MAX_WINDOW];
    int                            win_fill   = 0;
    int                            win_head   = 0;
    int                            win_sum    = 0;
    bit                            det_flag   = 1'b0;
    int                            on_run     = 0;
    int                            off_run    = 0;

    // Per-phase switches that turn off idling on either side.
    bit src_steady = 1'b0;
    bit dst_steady = 1'b0;

    int           src_gap;
    int           dst_stall;
    int           dst_pick;
    sample_beat_t next_beat;
    reading_t     want;
    int           failures    = 0;
    int           idle_cycles = 0;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic int saturating_inc(input int run);
        return (run >= int'(mahd_pkg::STREAK_MAX)) ? int'(mahd_pkg::STREAK_MAX) : run + 1;
    endfunction

    // Pushes one sample through the window and the detector and queues the
    // reading the block must return for it.
    function automatic void advance_light_window(input logic [mahd_pkg::SAMPLE_W-1:0] v);
        int       span;
        int       slot;
        reading_t r;
        span = int'(cfg_window_length);
        if (span < 1)
            span = 1;
        if (span > mahd_pkg::MAX_WINDOW)
            span = mahd_pkg::MAX_WINDOW;

        // A full window loses its oldest sample first. Note that the fill
        // count then comes back to where it was, so a window that was filled
        // under a larger length keeps that fill.
        if (win_fill >= span && win_fill > 0)
        begin
            win_sum  = win_sum - int'(win_mem[win_head]);
            win_head = (win_head + 1) % mahd_pkg::MAX_WINDOW;
            win_fill = win_fill - 1;
        end
        slot          = (win_head + win_fill) % mahd_pkg::MAX_WINDOW;
        win_mem[slot] = v;
        win_sum       = win_sum + int'(v);
        if (win_fill < mahd_pkg::MAX_WINDOW)
            win_fill = win_fill + 1;
        r.average = mahd_pkg::SAMPLE_W'(win_sum / win_fill);

        // The streak that a failing average feeds still counts, and it clears
        // the other one.
        if (!det_flag)
        begin
            if (r.average <= cfg_bright)
            begin
                on_run  = saturating_inc(on_run);
                off_run = 0;
            end
            else
            begin
                off_run = saturating_inc(off_run);
                on_run  = 0;
            end
            if (on_run >= int'(mahd_pkg::ON_COUNT))
                det_flag = 1'b1;
        end
        else
        begin
            if (r.average >= cfg_dark)
            begin
                off_run = saturating_inc(off_run);
                on_run  = 0;
            end
            else
            begin
                on_run  = saturating_inc(on_run);
                off_run = 0;
            end
            if (off_run >= int'(mahd_pkg::OFF_COUNT))
                det_flag = 1'b0;
        end
        r.light_detected   = det_flag;
        readings_in_flight = {readings_in_flight, r};
    endfunction

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Sender. An offered beat stays put until it is taken; after that the
    // next one follows at once or after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= '0;
            src_gap          <= 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                advance_light_window(sample_ch.sample);

            if (sample_ch.valid && !sample_ch.ready)
            begin
                // Beat still waiting; keep it unchanged.
            end
            else if (src_gap != 0)
            begin
                src_gap         <= src_gap - 1;
                sample_ch.valid <= 1'b0;
            end
            else if (samples_to_send.size() != 0 &&
                     !(samples_to_send[0].hold_off && readings_in_flight.size() != 0))
            begin
                next_beat = samples_to_send[0];
                samples_to_send.delete(0);
                sample_ch.valid  <= 1'b1;
                sample_ch.sample <= next_beat.sample;
                src_gap          <= pick_gap(src_steady);
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver. Each result beat is checked against the oldest prediction.
    // Ready drops for a random stall after some beats and now and then on its
    // own, so stalls land on every stage of the block's work.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            dst_stall       <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (readings_in_flight.size() == 0)
                begin
                    note_failure($sformatf("result beat with nothing predicted: average %0d flag %0b",
                                           result_ch.average, result_ch.light_detected));
                end
                else
                begin
                    want = readings_in_flight[0];
                    readings_in_flight.delete(0);
                    if (result_ch.average !== want.average)
                        note_failure($sformatf("average expected %0d got %0d",
                                               want.average, result_ch.average));
                    if (result_ch.light_detected !== want.light_detected)
                        note_failure($sformatf("light_detected expected %0b got %0b",
                                               want.light_detected,
                                               result_ch.light_detected));
                end
                dst_pick = pick_gap(dst_steady);
                dst_stall       <= dst_pick;
                result_ch.ready <= (dst_pick == 0);
            end
            else if (dst_stall != 0)
            begin
                dst_stall       <= dst_stall - 1;
                result_ch.ready <= (dst_stall == 1);
            end
            else
            begin
                dst_pick = ($urandom_range(0, 7) == 0) ? pick_gap(dst_steady) : 0;
                dst_stall       <= dst_pick;
                result_ch.ready <= (dst_pick == 0);
            end
        end
    end

    // Hang detection: a long stretch with no beat taken on either side ends
    // the run as a failure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("moving_average_hysteresis_detector_top regression: fail");
                $finish;
            end
        end
    end

    task automatic queue_sample(input int v, input bit hold_off);
        sample_beat_t b;
        b.sample        = mahd_pkg::SAMPLE_W'(v);
        b.hold_off      = hold_off;
        samples_to_send = {samples_to_send, b};
    endtask

    task automatic queue_repeat(input int v, input int count);
        repeat (count)
            queue_sample(v, 1'b0);
    endtask

    // Waits until every queued sample has gone out and every predicted
    // reading has arrived, then lets the block settle.
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || readings_in_flight.size() != 0 ||
               sample_ch.valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // One register write; our copy follows it since the block is idle.
    task automatic write_reg(input logic [mahd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mahd_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        unique case (idx)
            mahd_pkg::REG_WINDOW_LENGTH: cfg_window_length = data[mahd_pkg::WLEN_W-1:0];
            mahd_pkg::REG_BRIGHT_THRESH: cfg_bright        = data[mahd_pkg::SAMPLE_W-1:0];
            mahd_pkg::REG_DARK_THRESH:   cfg_dark          = data[mahd_pkg::SAMPLE_W-1:0];
            default:                     ;
        endcase
    endtask

    // Window length write with random junk above the five length bits.
    task automatic write_window_length(input int wlen);
        write_reg(mahd_pkg::REG_WINDOW_LENGTH,
                  {mahd_pkg::CFG_W'($urandom_range(0, 1023)) << mahd_pkg::WLEN_W}
                  | mahd_pkg::CFG_W'(wlen & 31));
    endtask

    // Random phase: mostly runs at or below the bright threshold or at or above
    // the dark one, long enough to build streaks, some runs between the two
    // thresholds that break streaks, and short runs of plain noise over the full
    // sample range. One beat in the middle waits until the block has drained.
    task automatic random_phase(input int n_items);
        int left;
        int run;
        int kind;
        int lo;
        int hi;
        left = n_items;
        while (left > 0)
        begin
            kind = $urandom_range(0, 9);
            run  = (kind < 7) ? $urandom_range(2, 20) : $urandom_range(1, 4);
            if (run > left)
                run = left;
            if (cfg_bright <= cfg_dark)
            begin
                lo = cfg_bright;
                hi = cfg_dark;
            end
            else
            begin
                lo = cfg_dark;
                hi = cfg_bright;
            end
            repeat (run)
            begin
                unique case (kind)
                    0, 1, 2: queue_sample($urandom_range(0, cfg_bright),
                                          left == n_items / 2);
                    3, 4, 5: queue_sample($urandom_range(cfg_dark, SAMPLE_MAX),
                                          left == n_items / 2);
                    6:       queue_sample($urandom_range(lo, hi), left == n_items / 2);
                    default: queue_sample($urandom_range(0, SAMPLE_MAX),
                                          left == n_items / 2);
                endcase
                left--;
            end
        end
    endtask

    task automatic random_thresholds();
        int b;
        b = $urandom_range(1000, 20000);
        write_reg(mahd_pkg::REG_BRIGHT_THRESH, mahd_pkg::CFG_W'(b));
        write_reg(mahd_pkg::REG_DARK_THRESH, mahd_pkg::CFG_W'(b + $urandom_range(0, 8000)));
    endtask

    initial
    begin
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // Directed part. A write to the unused index must change nothing.
        // A length of zero with junk above it acts as one, so each average is
        // the sample itself and the thresholds can be hit exactly; the
        // thresholds keep their reset values here.
        write_reg(REG_UNUSED, mahd_pkg::CFG_W'($urandom_range(0, SAMPLE_MAX)));
        write_reg(mahd_pkg::REG_WINDOW_LENGTH, mahd_pkg::CFG_W'(15'h7FE0));
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(0, 1'b0);           // one qualifying average only
        queue_sample(801, 1'b0);         // just above bright breaks the streak
        queue_repeat(800, 2);            // equal to bright twice turns it on
        queue_repeat(900, 5);            // five at dark is not yet enough
        queue_sample(899, 1'b0);         // breaks the dark streak
        queue_repeat(900, 6);            // six at dark turns it off
        queue_sample(15'h5555, 1'b0);
        queue_sample(15'h2AAA, 1'b0);
        wait_drained();

        // Longest window with the most extreme thresholds: only an average of zero is
        // at or below bright and only a full-scale average is at or above dark.
        write_window_length(mahd_pkg::MAX_WINDOW);
        write_reg(mahd_pkg::REG_BRIGHT_THRESH, '0);
        write_reg(mahd_pkg::REG_DARK_THRESH, mahd_pkg::CFG_W'(SAMPLE_MAX));
        queue_repeat(SAMPLE_MAX, 3);
        queue_repeat(0, 3);
        wait_drained();

        // Random phases over several window lengths, including a drop to one
        // while the window is full, clamped lengths above the maximum and zero.
        for (int phase = 0; phase < 7; phase++)
        begin
            src_steady = ($urandom_range(0, 3) == 0);
            dst_steady = ($urandom_range(0, 3) == 0);
            unique case (phase)
                0: write_window_length(mahd_pkg::MAX_WINDOW);
                1: write_window_length(1);
                2: write_window_length(31);
                3: write_window_length(0);
                4: write_window_length($urandom_range(mahd_pkg::MAX_WINDOW + 1, 30));
                default: write_window_length($urandom_range(2, mahd_pkg::MAX_WINDOW - 1));
            endcase
            if (phase == 5)
            begin
                write_reg(mahd_pkg::REG_BRIGHT_THRESH, mahd_pkg::CFG_W'(SAMPLE_MAX));
                write_reg(mahd_pkg::REG_DARK_THRESH, '0);
            end
            else if (phase == 6)
            begin
                write_reg(mahd_pkg::REG_BRIGHT_THRESH, '0);
                write_reg(mahd_pkg::REG_DARK_THRESH, mahd_pkg::CFG_W'(SAMPLE_MAX));
            end
            else
            begin
                random_thresholds();
            end
            random_phase(33);
            wait_drained();
        end

        // A long steady stretch: the detector turns on and then sees hundreds
        // of averages below dark, so its streak counter runs into saturation
        // before a run of averages at or above dark turns it off again.
        src_steady = 1'b0;
        dst_steady = 1'b0;
        write_window_length(mahd_pkg::MAX_WINDOW);
        write_reg(mahd_pkg::REG_BRIGHT_THRESH, mahd_pkg::CFG_W'(16000));
        write_reg(mahd_pkg::REG_DARK_THRESH, mahd_pkg::CFG_W'(16001));
        repeat (270)
            queue_sample($urandom_range(0, 8000), 1'b0);
        repeat (30)
            queue_sample($urandom_range(24000, SAMPLE_MAX), 1'b0);
        wait_drained();

        if (failures == 0 && readings_in_flight.size() == 0)
            $display("moving_average_hysteresis_detector_top regression: pass");
        else
            $display("moving_average_hysteresis_detector_top regression: fail");
        $finish;
    end

endmodule
